[hw/rtl/vco_pkg.sv]
`timescale 1ns / 1ps

package vco_pkg;

    // Column store geometry.
    localparam int MAX_COLUMNS = 1024;
    localparam int COL_AW      = $clog2(MAX_COLUMNS);
    localparam int TOP_W       = 16;

    // Field widths.
    localparam int COLUMN_W  = 10;
    localparam int TERRAIN_W = 8;
    localparam int DEPTH_W   = 20;
    localparam int COLOR_W   = 32;
    localparam int CAM_W     = 10;
    localparam int HOR_W     = 11;
    localparam int SCALE_W   = 16;
    localparam int FH_W      = 12;
    localparam int SPAN_TOP_W = 11;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_ROW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd3;

    localparam logic [CAM_W-1:0]   RESET_CAMERA_HEIGHT = 10'd128;
    localparam logic [HOR_W-1:0]   RESET_HORIZON_ROW   = 11'd120;
    localparam logic [SCALE_W-1:0] RESET_HEIGHT_SCALE  = 16'd30720;
    localparam logic [FH_W-1:0]    RESET_FRAME_HEIGHT  = 12'd480;
    localparam logic [FH_W-1:0]    FH_MAX              = 12'd2048;

    // Request opcodes.
    localparam logic OP_FRAME_START = 1'b0;
    localparam logic OP_SAMPLE      = 1'b1;

    // Divider widths: the magnitude of the projection numerator, the depth,
    // and a quotient whose top bit flags saturation.
    localparam int DIVD_W = 32;
    localparam int DIVS_W = DEPTH_W;
    localparam int QUOT_W = 16;
    localparam int DSH_W  = DIVS_W + QUOT_W - 1;
    localparam int CNT_W  = $clog2(QUOT_W + 1);

    typedef struct packed {
        logic                 op;
        logic [COLUMN_W-1:0]  column;
        logic [TERRAIN_W-1:0] elevation;
        logic [DEPTH_W-1:0]   depth;
        logic [COLOR_W-1:0]   color;
    } t_sample;

    typedef struct packed {
        logic [COLUMN_W-1:0]   span_column;
        logic [SPAN_TOP_W-1:0] span_top;
        logic [FH_W-1:0]       span_bottom;
        logic [COLOR_W-1:0]    span_color;
    } t_span;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } t_div_res;

endpackage

[hw/rtl/vco_sample_if.sv]
`timescale 1ns / 1ps

interface vco_sample_if import vco_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/vco_span_if.sv]
`timescale 1ns / 1ps

interface vco_span_if import vco_pkg::*; ();
    logic  valid;
    logic  ready;
    t_span payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/vco_ram.sv]
`timescale 1ns / 1ps

module vco_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/vco_div.sv]
`timescale 1ns / 1ps

// Radix-2 restoring divider, one quotient bit per cycle. The top quotient
// bit is only meaningful as an overflow flag: once it is set, the lower
// bits are not used.
module vco_div import vco_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_res o_res
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [QUOT_W-1:0] r_q;
    logic              ge;

    assign ge = {{(DSH_W-DIVD_W){1'b0}}, r_rem} >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(QUOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dsh <= DSH_W'(i_req.divisor) << (QUOT_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - DIVD_W'(r_dsh);
            end
            r_q   <= {r_q[QUOT_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_q;

endmodule

[hw/rtl/voxel_column_occlusion_unit.sv]
`timescale 1ns / 1ps

// Per-column occlusion core of a voxel-space terrain renderer. Each terrain
// sample request is projected to a screen row, trunc((camera_height -
// elevation) * height_scale / depth + horizon_row), saturated to a
// signed 16-bit row, and compared with the stored top of its column. When
// the row lies above that top, one span request goes out (top clamped to
// 0..frame_height-1, bottom clamped to 0..frame_height) and the row becomes
// the new top. A frame-start request emits nothing and rewrites every
// column top with the frame height. The block handles one request at a
// time. A sample passes from its acceptance through the states SUM, which
// adds the two products and picks up the column top; PREP, which loads the
// divider; DIV, in which the radix-2 divider makes its 16 quotient bits,
// one per cycle, and is seen to finish; DONE, which commits the span; and
// IDLE, in which the next request is taken. DONE registers the span in the
// output register; a span that cannot leave because the output register is
// still full holds the block until the receiver takes it. A frame-start
// request, and likewise the period right after reset, runs a clearing pass
// over all MAX_COLUMNS entries of the column store (1024 by default),
// during which no request is accepted; configuration writes are taken at
// any time. A finished span waits in an output register, so the next
// request is accepted while the span is still pending. Configuration
// must only be written while the block is idle.
module voxel_column_occlusion_unit import vco_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vco_sample_if.sink            i_sample,
    vco_span_if.source            o_span,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Configuration registers.
    logic [CAM_W-1:0]   r_cam;
    logic [HOR_W-1:0]   r_hor;
    logic [SCALE_W-1:0] r_scale;
    logic [FH_W-1:0]    r_fh;
    logic [FH_W-1:0]    fh_eff;
    logic [FH_W-1:0]    fh_m1;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Clearing pass.
    logic [COL_AW-1:0] r_clr_addr;
    logic [TOP_W-1:0]  r_clr_val;
    logic              clr_last;

    // Sample datapath registers.
    logic [COL_AW-1:0]         r_col;
    logic [COLUMN_W-1:0]       r_column;
    logic [COLOR_W-1:0]        r_color;
    logic [DEPTH_W-1:0]        r_depth;
    logic signed [27:0]        r_p1;
    logic [30:0]               r_p2;
    logic signed [32:0]        r_num;
    logic signed [TOP_W-1:0]   r_top;
    logic                      r_neg;

    // Output register.
    logic  r_out_valid;
    t_span r_out;

    logic                    in_acc;
    logic                    in_sample;
    logic                    col_ok;
    logic [DEPTH_W-1:0]      depth_eff;
    logic signed [10:0]      diff;
    logic signed [16:0]      scale_s;
    logic                    out_free;
    logic                    emit;
    logic                    commit;
    logic signed [TOP_W-1:0] row;
    logic signed [TOP_W-1:0] q_s;
    logic [SPAN_TOP_W-1:0]   span_top;
    logic [FH_W-1:0]         span_bottom;

    logic              mem_we;
    logic [COL_AW-1:0] mem_waddr;
    logic [TOP_W-1:0]  mem_wdata;
    logic [TOP_W-1:0]  mem_rdata;

    t_div_req div_req;
    t_div_res div_res;

    // The frame height register is saturated to 1..2048 wherever it is used.
    always_comb begin
        if (r_fh == '0) begin
            fh_eff = FH_W'(1);
        end else if (r_fh > FH_MAX) begin
            fh_eff = FH_MAX;
        end else begin
            fh_eff = r_fh;
        end
    end
    assign fh_m1 = fh_eff - FH_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam   <= RESET_CAMERA_HEIGHT;
            r_hor   <= RESET_HORIZON_ROW;
            r_scale <= RESET_HEIGHT_SCALE;
            r_fh    <= RESET_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CAMERA_HEIGHT: r_cam   <= i_cfg_data[CAM_W-1:0];
                CFG_HORIZON_ROW:   r_hor   <= i_cfg_data[HOR_W-1:0];
                CFG_HEIGHT_SCALE:  r_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_FRAME_HEIGHT:  r_fh    <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Input handshake. Requests are taken only when the sequencer is idle.
    assign i_sample.ready = (r_state == S_IDLE);
    assign in_acc         = i_sample.valid && i_sample.ready;
    assign col_ok         = 32'(i_sample.payload.column) < MAX_COLUMNS;
    assign in_sample      = in_acc && (i_sample.payload.op == OP_SAMPLE) && col_ok;

    // A depth below 1.0 is treated as 1.0.
    assign depth_eff = (i_sample.payload.depth < DEPTH_W'(256)) ? DEPTH_W'(256)
                                                                : i_sample.payload.depth;
    assign diff    = $signed({1'b0, r_cam}) - $signed({3'b000, i_sample.payload.elevation});
    assign scale_s = $signed({1'b0, r_scale});

    // The two products of the numerator are formed in the accept cycle; the
    // fractional parts of scale and depth cancel, so the row is
    // (diff * scale + horizon * depth) / depth.
    always_ff @(posedge i_clk) begin
        if (in_sample) begin
            r_col    <= COL_AW'(i_sample.payload.column);
            r_column <= i_sample.payload.column;
            r_color  <= i_sample.payload.color;
            r_depth  <= depth_eff;
            r_p1     <= diff * scale_s;
            r_p2     <= r_hor * depth_eff;
        end
        if (r_state == S_SUM) begin
            r_num <= $signed({{5{r_p1[27]}}, r_p1}) + $signed({2'b00, r_p2});
            r_top <= $signed(mem_rdata);
        end
        if (r_state == S_PREP) begin
            r_neg <= r_num[32];
        end
    end

    // The divider works on the magnitude; the sign is put back afterwards so
    // that the quotient truncates toward zero.
    always_comb begin
        div_req.start    = (r_state == S_PREP);
        div_req.dividend = r_num[32] ? DIVD_W'(-r_num) : DIVD_W'(r_num);
        div_req.divisor  = r_depth;
    end

    vco_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    // A set top quotient bit means the magnitude reached 2^15 and the row
    // saturates toward the sign of the numerator.
    assign q_s = $signed({1'b0, div_res.quotient[QUOT_W-2:0]});
    always_comb begin
        if (div_res.quotient[QUOT_W-1]) begin
            row = r_neg ? $signed(16'h8000) : $signed(16'h7fff);
        end else begin
            row = r_neg ? -q_s : q_s;
        end
    end

    always_comb begin
        if (row < 0) begin
            span_top = '0;
        end else if (row > $signed({4'b0000, fh_m1})) begin
            span_top = SPAN_TOP_W'(fh_m1);
        end else begin
            span_top = SPAN_TOP_W'(row);
        end
    end

    always_comb begin
        if (r_top < 0) begin
            span_bottom = '0;
        end else if (r_top > $signed({4'b0000, fh_eff})) begin
            span_bottom = fh_eff;
        end else begin
            span_bottom = FH_W'(r_top);
        end
    end

    // A span goes out only when the new row lies strictly above the stored
    // top; it is committed once the output register can take it.
    assign out_free = !r_out_valid || o_span.ready;
    assign emit     = (row < r_top);
    assign commit   = (r_state == S_DONE) && emit && out_free;
    assign clr_last = (r_clr_addr == COL_AW'(MAX_COLUMNS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc && (i_sample.payload.op == OP_FRAME_START)) begin
                    n_state = S_CLEAR;
                end else if (in_sample) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:  n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!emit || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_clr_val  <= TOP_W'(RESET_FRAME_HEIGHT);
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + COL_AW'(1);
            end
            if (in_acc && (i_sample.payload.op == OP_FRAME_START)) begin
                r_clr_addr <= '0;
                r_clr_val  <= TOP_W'(fh_eff);
            end
        end
    end

    // Column store: the clearing pass and the sample write-back share the
    // single write port; reads are issued when a sample is accepted.
    assign mem_we    = (r_state == S_CLEAR) || commit;
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_col;
    assign mem_wdata = (r_state == S_CLEAR) ? r_clr_val : TOP_W'(row);

    vco_ram #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (TOP_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_sample),
        .i_raddr (COL_AW'(i_sample.payload.column)),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_span.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out.span_column <= r_column;
            r_out.span_top    <= span_top;
            r_out.span_bottom <= span_bottom;
            r_out.span_color  <= r_color;
        end
    end

    assign o_span.valid   = r_out_valid;
    assign o_span.payload = r_out;

endmodule
